>>> sv/pbe_pkg.sv
// Shared types and constants of the PackBits encoder.
`timescale 1ns / 1ps
`default_nettype none

package pbe_pkg;

  // End-of-data marker appended after the final record of a block
  localparam logic [7:0] END_MARKER   = 8'd128;
  // Run header is (257 - length) mod 256
  localparam logic [8:0] RUN_HDR_BASE = 9'd257;
  // Bytes per output word
  localparam int         WORD_BYTES   = 8;

  // Input transaction: one raw byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } pbe_in_t;

  // Output transaction: one packed word of encoded bytes
  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_step;
    logic        stream_done;
  } pbe_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIT_HDR,
    ST_LIT_DATA,
    ST_RUN_HDR,
    ST_RUN_VAL,
    ST_FIN_ADD,
    ST_MARKER
  } pbe_state_t;

  // Source of the byte pushed into the packer
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_LIT_HDR,
    EMIT_LIT_DATA,
    EMIT_RUN_HDR,
    EMIT_RUN_VAL,
    EMIT_MARKER
  } pbe_emit_t;

  // How an incoming byte relates to the pending state
  typedef enum logic [2:0] {
    CLS_RUN_GROW,
    CLS_RUN_BREAK,
    CLS_RUN_START,
    CLS_LIT_ADD,
    CLS_HOLD
  } pbe_cls_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    pbe_emit_t emit_sel;
    logic      emit_end;
    logic      fin_add;
    logic      run_hold;
  } pbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    pbe_cls_t cls;
    logic     in_last;
    logic     lit_fill;
    logic     lit_nonempty;
    logic     lit_last;
    logic     run_active;
    logic     held_valid;
    logic     cur_last;
    logic     push_ok;
    logic     pack_empty;
  } pbe_sts_t;

endpackage

`default_nettype wire

>>> sv/pbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire [WIDTH-1:0]           wr_data,
  input  wire [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> sv/pbe_packer.sv
// Byte-to-word packer with an output register on the word channel.
`timescale 1ns / 1ps
`default_nettype none

module pbe_packer (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [7:0]        push_byte,
  input  wire              push_end,
  input  wire              push_done,
  output logic             push_ok,
  output logic             empty,
  output logic             word_valid,
  input  wire              word_ready,
  output pbe_pkg::pbe_out_t word_item
);

  import pbe_pkg::*;

  localparam int LANE_W = $clog2(WORD_BYTES);

  logic [7:0]        acc [WORD_BYTES-1];
  logic [LANE_W-1:0] acc_cnt;
  logic              out_free;
  logic              complete;
  logic              push_fire;
  logic [63:0]       word_bytes;

  // A word closes on the last byte of a step or when its lanes are full
  assign out_free  = !word_valid || word_ready;
  assign complete  = push_end || (acc_cnt == LANE_W'(WORD_BYTES - 1));
  assign push_ok   = !complete || out_free;
  assign push_fire = push && push_ok;
  assign empty     = (acc_cnt == '0);

  // Assemble the closing word; lanes past the count stay zero
  always_comb begin
    word_bytes = '0;
    for (int j = 0; j < WORD_BYTES; j++) begin
      if (LANE_W'(j) == acc_cnt) begin
        word_bytes[8*j +: 8] = push_byte;
      end
    end
    for (int j = 0; j < WORD_BYTES - 1; j++) begin
      if (LANE_W'(j) < acc_cnt) begin
        word_bytes[8*j +: 8] = acc[j];
      end
    end
  end

  // Control: lane count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt    <= '0;
      word_valid <= 1'b0;
    end else begin
      if (push_fire) begin
        acc_cnt <= complete ? '0 : acc_cnt + LANE_W'(1);
      end
      if (push_fire && complete) begin
        word_valid <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
    end
  end

  // Payload: accumulator lanes and output word
  always_ff @(posedge clk) begin
    if (push_fire) begin
      if (complete) begin
        word_item.out_bytes    <= word_bytes;
        word_item.byte_count   <= 4'(acc_cnt) + 4'd1;
        word_item.last_of_step <= push_end;
        word_item.stream_done  <= push_done;
      end else begin
        acc[acc_cnt] <= push_byte;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/pbe_datapath.sv
// Encoder datapath: run and literal state, literal store, byte select and packer.
`timescale 1ns / 1ps
`default_nettype none

module pbe_datapath #(
  parameter int MAX_RECORD = 128
) (
  input  wire               clk,
  input  wire               rst,
  input  wire pbe_pkg::pbe_in_t  byte_item,
  input  wire pbe_pkg::pbe_cmd_t cmd,
  output pbe_pkg::pbe_sts_t sts,
  output logic              word_valid,
  input  wire               word_ready,
  output pbe_pkg::pbe_out_t word_item
);

  import pbe_pkg::*;

  localparam int ADDR_W = $clog2(MAX_RECORD);
  localparam int CNT_W  = $clog2(MAX_RECORD + 1);
  localparam logic [CNT_W-1:0] RUN_START_LEN = CNT_W'(2);

  logic [7:0]        cur_byte;
  logic              cur_last;
  logic [CNT_W-1:0]  lit_cnt;
  logic [CNT_W-1:0]  run_len;
  logic [7:0]        run_value;
  logic [7:0]        held_value;
  logic              held_valid;
  logic [ADDR_W-1:0] idx;

  pbe_cls_t          cls;
  logic              ram_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        emit_byte;
  logic              push;
  logic              push_ok;
  logic              push_fire;
  logic              pack_empty;
  logic              lit_last;

  // Classify the offered byte against the pending run or held byte
  always_comb begin
    priority if (run_len != '0) begin
      cls = (byte_item.data_byte == run_value && run_len != CNT_W'(MAX_RECORD)) ?
            CLS_RUN_GROW : CLS_RUN_BREAK;
    end else if (held_valid) begin
      cls = (held_value == byte_item.data_byte) ? CLS_RUN_START : CLS_LIT_ADD;
    end else begin
      cls = CLS_HOLD;
    end
  end

  // Literal store: held byte goes in at the current literal count
  assign ram_we = (cmd.accept && cls == CLS_LIT_ADD) || (cmd.fin_add && held_valid);

  pbe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RECORD)
  ) u_lit_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (lit_cnt[ADDR_W-1:0]),
    .wr_data (held_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read address runs one ahead of the byte being pushed
  always_comb begin
    if (cmd.emit_sel == EMIT_LIT_DATA) begin
      rd_addr = push_ok ? idx + ADDR_W'(1) : idx;
    end else begin
      rd_addr = '0;
    end
  end

  assign lit_last = (CNT_W'(idx) + CNT_W'(1)) == lit_cnt;

  // Encoded byte select
  always_comb begin
    unique case (cmd.emit_sel)
      EMIT_LIT_HDR:  emit_byte = 8'(lit_cnt) - 8'd1;
      EMIT_LIT_DATA: emit_byte = rd_data;
      EMIT_RUN_HDR:  emit_byte = 8'(RUN_HDR_BASE - 9'(run_len));
      EMIT_RUN_VAL:  emit_byte = run_value;
      EMIT_MARKER:   emit_byte = END_MARKER;
      default:       emit_byte = 8'd0;
    endcase
  end

  assign push      = (cmd.emit_sel != EMIT_NONE);
  assign push_fire = push && push_ok;

  pbe_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_byte  (emit_byte),
    .push_end   (cmd.emit_end),
    .push_done  (cmd.emit_sel == EMIT_MARKER),
    .push_ok    (push_ok),
    .empty      (pack_empty),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_item  (word_item)
  );

  // Encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_last   <= 1'b0;
      lit_cnt    <= '0;
      run_len    <= '0;
      run_value  <= 8'd0;
      held_value <= 8'd0;
      held_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cur_last <= byte_item.block_end;
        unique case (cls)
          CLS_RUN_GROW: run_len <= run_len + CNT_W'(1);
          CLS_RUN_BREAK: ;
          CLS_RUN_START: begin
            run_value  <= byte_item.data_byte;
            run_len    <= RUN_START_LEN;
            held_valid <= 1'b0;
          end
          CLS_LIT_ADD: begin
            lit_cnt    <= lit_cnt + CNT_W'(1);
            held_value <= byte_item.data_byte;
          end
          CLS_HOLD: begin
            held_value <= byte_item.data_byte;
            held_valid <= 1'b1;
          end
          default: ;
        endcase
      end
      // block end: the held byte joins the literal
      if (cmd.fin_add && held_valid) begin
        lit_cnt    <= lit_cnt + CNT_W'(1);
        held_valid <= 1'b0;
      end
      if (push_fire) begin
        unique case (cmd.emit_sel)
          EMIT_LIT_DATA: begin
            if (lit_last) begin
              lit_cnt <= '0;
            end
          end
          EMIT_RUN_VAL: begin
            run_len <= '0;
            if (cmd.run_hold) begin
              held_value <= cur_byte;
              held_valid <= 1'b1;
            end
          end
          EMIT_MARKER: begin
            lit_cnt    <= '0;
            run_len    <= '0;
            run_value  <= 8'd0;
            held_value <= 8'd0;
            held_valid <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Captured byte and literal read index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_byte <= byte_item.data_byte;
    end
    if (cmd.emit_sel == EMIT_LIT_HDR) begin
      idx <= '0;
    end else if (push_fire && cmd.emit_sel == EMIT_LIT_DATA) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // Status to the controller
  assign sts.cls          = cls;
  assign sts.in_last      = byte_item.block_end;
  assign sts.lit_fill     = (lit_cnt == CNT_W'(MAX_RECORD - 1));
  assign sts.lit_nonempty = (lit_cnt != '0);
  assign sts.lit_last     = lit_last;
  assign sts.run_active   = (run_len != '0);
  assign sts.held_valid   = held_valid;
  assign sts.cur_last     = cur_last;
  assign sts.push_ok      = push_ok;
  assign sts.pack_empty   = pack_empty;

endmodule

`default_nettype wire

>>> sv/pbe_ctrl.sv
// Encoder controller: sequences accept, record emission and block-end flush.
`timescale 1ns / 1ps
`default_nettype none

module pbe_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               byte_valid,
  output logic              byte_ready,
  input  wire pbe_pkg::pbe_sts_t sts,
  output pbe_pkg::pbe_cmd_t cmd
);

  import pbe_pkg::*;

  pbe_state_t state;
  pbe_state_t state_next;
  logic       fin;
  logic       fin_next;

  // State register; fin marks the block-end flush phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    fin_next   = fin;
    cmd        = '0;
    byte_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        byte_ready = 1'b1;
        cmd.accept = byte_valid;
        if (byte_valid) begin
          fin_next = 1'b0;
          priority if (sts.cls == CLS_RUN_BREAK) begin
            state_next = ST_RUN_HDR;
          end else if ((sts.cls == CLS_RUN_START && sts.lit_nonempty) ||
                       (sts.cls == CLS_LIT_ADD && sts.lit_fill)) begin
            state_next = ST_LIT_HDR;
          end else if (sts.in_last) begin
            state_next = ST_FIN_ADD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LIT_HDR: begin
        cmd.emit_sel = EMIT_LIT_HDR;
        if (sts.push_ok) begin
          state_next = ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        cmd.emit_sel = EMIT_LIT_DATA;
        cmd.emit_end = !sts.cur_last && sts.lit_last;
        if (sts.push_ok && sts.lit_last) begin
          priority if (!sts.cur_last) begin
            state_next = ST_IDLE;
          end else if (!fin) begin
            state_next = ST_FIN_ADD;
          end else if (sts.run_active) begin
            state_next = ST_RUN_HDR;
          end else begin
            state_next = ST_MARKER;
          end
        end
      end
      ST_RUN_HDR: begin
        cmd.emit_sel = EMIT_RUN_HDR;
        if (sts.push_ok) begin
          state_next = ST_RUN_VAL;
        end
      end
      ST_RUN_VAL: begin
        cmd.emit_sel = EMIT_RUN_VAL;
        cmd.emit_end = !sts.cur_last;
        cmd.run_hold = !fin;
        if (sts.push_ok) begin
          priority if (!sts.cur_last) begin
            state_next = ST_IDLE;
          end else if (!fin) begin
            state_next = ST_FIN_ADD;
          end else begin
            state_next = ST_MARKER;
          end
        end
      end
      ST_FIN_ADD: begin
        cmd.fin_add = 1'b1;
        fin_next    = 1'b1;
        priority if (sts.held_valid || sts.lit_nonempty) begin
          state_next = ST_LIT_HDR;
        end else if (sts.run_active) begin
          state_next = ST_RUN_HDR;
        end else begin
          state_next = ST_MARKER;
        end
      end
      ST_MARKER: begin
        cmd.emit_sel = EMIT_MARKER;
        cmd.emit_end = 1'b1;
        if (sts.push_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/packbits_encoder.sv
// PackBits encoder top level: one raw byte per input transaction, packed words out.
// Sequencing: a byte is accepted in ST_IDLE; if it closes a record, each encoded byte is then
//   pushed in turn, plus a flush step (ST_FIN_ADD) and the end marker on a block end;
//   each word is presented the cycle after its final byte leaves the single-byte emitter.
// Throughput: 1 byte per cycle while no record is emitted and no block ends; emitting a
//   record (header, then data or value) holds the input, and output back-pressure holds it longer.
// Reset: synchronous, clears control and encoder state; the literal store needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module packbits_encoder #(
  parameter int MAX_RECORD = 128
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               byte_valid,
  output logic              byte_ready,
  input  wire pbe_pkg::pbe_in_t  byte_item,
  output logic              word_valid,
  input  wire               word_ready,
  output pbe_pkg::pbe_out_t word_item
);

  import pbe_pkg::*;

  pbe_cmd_t cmd;
  pbe_sts_t sts;

  pbe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pbe_datapath #(
    .MAX_RECORD (MAX_RECORD)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .byte_item  (byte_item),
    .cmd        (cmd),
    .sts        (sts),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_item  (word_item)
  );

  // Every step closes its last word, so no partial word waits between transactions
  a_idle_pack_empty: assert property (@(posedge clk) disable iff (rst)
    byte_ready |-> sts.pack_empty)
    else $error("partial output word left between transactions");

  // The end marker leaves the encoder fully idle
  a_marker_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sel == EMIT_MARKER && sts.push_ok)
    |=> (!sts.run_active && !sts.held_valid && !sts.lit_nonempty))
    else $error("state not cleared after end marker");

  // Literal data is only read while a literal is pending
  a_lit_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sel == EMIT_LIT_DATA) |-> sts.lit_nonempty)
    else $error("literal read with empty literal");

  // Flush phase never begins with a held byte and a run both pending
  a_fin_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_add |-> !(sts.held_valid && sts.run_active))
    else $error("held byte and active run at block end");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the PackBits encoder: byte stimulus, word predictor and checks.
`timescale 1ns / 1ps

// Longest run or literal record that the encoder builds
localparam int REC_LIMIT = 128;

// Predicts the encoded words of every accepted byte and checks the words that come out
class packbits_scoreboard;
  logic [7:0]        lit_buf [REC_LIMIT];
  int unsigned       lit_n;
  logic [7:0]        run_byte;
  int unsigned       run_n;
  logic [7:0]        held_byte;
  bit                held_ok;
  logic [7:0]        step_bytes [$];
  pbe_pkg::pbe_out_t expected_words [$];
  int                fails;

  function new();
    lit_n     = 0;
    run_byte  = '0;
    run_n     = 0;
    held_byte = '0;
    held_ok   = 1'b0;
    fails     = 0;
  endfunction

  function void push_byte(logic [7:0] b);
    step_bytes = {step_bytes, b};
  endfunction

  // Literal record: header length-1, then the stored bytes
  function void close_literal();
    if (lit_n == 0) return;
    push_byte(8'(lit_n - 1));
    for (int k = 0; k < lit_n; k++) push_byte(lit_buf[k]);
    lit_n = 0;
  endfunction

  // Run record: header (257 - length) mod 256, then the byte
  function void close_run();
    logic [8:0] hdr;
    if (run_n == 0) return;
    hdr = pbe_pkg::RUN_HDR_BASE - 9'(run_n);
    push_byte(hdr[7:0]);
    push_byte(run_byte);
    run_n = 0;
  endfunction

  function void append_literal(logic [7:0] b);
    lit_buf[lit_n[6:0]] = b;
    lit_n++;
    if (lit_n >= REC_LIMIT) close_literal();
  endfunction

  // One accepted byte: update the encoder state and queue the words it causes
  function void encode_byte(pbe_pkg::pbe_in_t it);
    logic [7:0]        b;
    bit                fin;
    int                nb;
    int                nw;
    int                idx;
    pbe_pkg::pbe_out_t w;
    step_bytes.delete();
    b   = it.data_byte;
    fin = it.block_end;
    if (run_n > 0) begin
      if (b == run_byte && run_n < REC_LIMIT) begin
        run_n++;
      end else begin
        close_run();
        held_byte = b;
        held_ok   = 1'b1;
      end
    end else if (held_ok) begin
      if (held_byte == b) begin
        close_literal();
        run_byte = b;
        run_n    = 2;
        held_ok  = 1'b0;
      end else begin
        append_literal(held_byte);
        held_byte = b;
      end
    end else begin
      held_byte = b;
      held_ok   = 1'b1;
    end
    // End of block: the byte still held has no partner and joins the literal
    if (fin) begin
      if (held_ok) begin
        append_literal(held_byte);
        held_ok = 1'b0;
      end
      close_literal();
      close_run();
      push_byte(pbe_pkg::END_MARKER);
      held_byte = '0;
      run_byte  = '0;
    end
    // Pack the step's bytes into words, first byte lowest
    nb = step_bytes.size();
    nw = (nb + pbe_pkg::WORD_BYTES - 1) / pbe_pkg::WORD_BYTES;
    for (int k = 0; k < nw; k++) begin
      w = '0;
      for (int j = 0; j < pbe_pkg::WORD_BYTES; j++) begin
        idx = k * pbe_pkg::WORD_BYTES + j;
        if (idx < nb) begin
          w.out_bytes[8*j +: 8] = step_bytes[idx];
          w.byte_count++;
        end
      end
      w.last_of_step = (k == nw - 1);
      w.stream_done  = fin && (k == nw - 1);
      expected_words = {expected_words, w};
    end
  endfunction

  // One accepted word against the oldest expected word
  function void check_word(pbe_pkg::pbe_out_t got);
    pbe_pkg::pbe_out_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected word: out_bytes %h byte_count %0d", got.out_bytes, got.byte_count);
      fails++;
      return;
    end
    want = expected_words.pop_front();
    if (got.out_bytes !== want.out_bytes) begin
      $error("out_bytes: expected %h, actual %h", want.out_bytes, got.out_bytes);
      fails++;
    end
    if (got.byte_count !== want.byte_count) begin
      $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
      fails++;
    end
    if (got.last_of_step !== want.last_of_step) begin
      $error("last_of_step: expected %b, actual %b", want.last_of_step, got.last_of_step);
      fails++;
    end
    if (got.stream_done !== want.stream_done) begin
      $error("stream_done: expected %b, actual %b", want.stream_done, got.stream_done);
      fails++;
    end
  endfunction
endclass

module testbench;

  localparam int  RAND_ITEMS = 120;
  localparam int  LONG_HOLD  = 400;
  localparam int  TAIL_WAIT  = 150;
  localparam time TIMEOUT_NS = 5_000_000;

  logic              clk;
  logic              rst;
  logic              byte_valid;
  logic              byte_ready;
  pbe_pkg::pbe_in_t  byte_item;
  logic              word_valid;
  logic              word_ready;
  pbe_pkg::pbe_out_t word_item;

  packbits_scoreboard sb;
  logic [7:0]         blk_q [$];
  bit                 long_hold;

  packbits_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_item  (word_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // Block building: a run of equal bytes, a literal with no two adjacent bytes equal
  task automatic add_run(input logic [7:0] val, input int len);
    repeat (len) blk_q = {blk_q, val};
  endtask

  task automatic add_literal(input int len);
    logic [7:0] prev;
    prev = (blk_q.size() > 0) ? blk_q[$] : 8'($urandom);
    repeat (len) begin
      prev = prev ^ 8'($urandom_range(1, 255));
      blk_q = {blk_q, prev};
    end
  endtask

  // Send the queued block, block_end on its final byte; entered and left at a falling edge
  task automatic send_block(input bit burst);
    pbe_pkg::pbe_in_t it;
    int               gap;
    for (int i = 0; i < blk_q.size(); i++) begin
      gap = burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        byte_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      it.data_byte = blk_q[i];
      it.block_end = (i == blk_q.size() - 1);
      byte_item    = it;
      byte_valid   = 1'b1;
      do @(posedge clk); while (!byte_ready);
      sb.encode_byte(it);
      @(negedge clk);
    end
    // Nothing offered once the block is out
    byte_valid = 1'b0;
    blk_q.delete();
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  // Word sink: random ready gaps, calm stretches, one long hold on request
  initial begin : word_sink
    int gap;
    int calm;
    calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        word_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        gap  = 0;
        calm = $urandom_range(10, 40);
      end else begin
        gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
        word_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      word_ready = 1'b1;
      do @(posedge clk); while (!word_valid);
      sb.check_word(word_item);
      @(negedge clk);
    end
  end

  // Byte source: directed blocks, long records, then random blocks
  initial begin : byte_source
    int rand_items;
    int blk_no;
    int kind;
    int len;
    bit burst;
    sb         = new();
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_item  = '0;
    word_ready = 1'b0;
    long_hold  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single byte: held at the end, it becomes a one-byte literal
    blk_q = '{8'h00};
    send_block(1'b0);
    // Shortest run, all ones
    blk_q = '{8'hFF, 8'hFF};
    send_block(1'b0);
    // Plain literal
    blk_q = '{8'h55, 8'hAA, 8'h01};
    send_block(1'b0);
    // Literal closed by a run
    blk_q = '{8'h12, 8'h34, 8'h34, 8'h34};
    send_block(1'b1);
    // Run broken by a byte that ends the block
    blk_q = '{8'h07, 8'h07, 8'h08};
    send_block(1'b0);
    // Literal, run, literal
    blk_q = '{8'hA5, 8'h5A, 8'hC3, 8'hC3, 8'h3C};
    send_block(1'b1);
    // Literal that fills a whole word, so the end marker spills into a second word
    blk_q = '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h10, 8'hEF, 8'h00};
    send_block(1'b0);
    wait_drained();

    // Full run followed by one more equal byte, then a literal that fills its record
    add_run(8'($urandom), REC_LIMIT + 1);
    add_literal(REC_LIMIT);
    send_block(1'b0);

    rand_items = 0;
    blk_no     = 0;
    while (rand_items < RAND_ITEMS) begin
      repeat ($urandom_range(1, 5)) begin
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 24) == 0) ? $urandom_range(REC_LIMIT - 2, REC_LIMIT + 3)
                                            : $urandom_range(1, 7);
        if (kind < 4) begin
          add_run(8'($urandom), len + 1);
        end else if (kind < 8) begin
          add_literal(len);
        end else begin
          // Noise from a small or a full alphabet
          repeat (len) blk_q = {blk_q, ($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                             : 8'($urandom))};
        end
      end
      // Output held off while back-to-back blocks keep coming
      if (blk_no == 2) long_hold = 1'b1;
      // Let the pipeline empty once mid-run
      if (blk_no == 7) wait_drained();
      burst = (blk_no >= 2 && blk_no < 6) || ($urandom_range(0, 3) == 0);
      rand_items += blk_q.size();
      send_block(burst);
      blk_no++;
    end
    byte_valid = 1'b0;

    wait_drained();
    repeat (TAIL_WAIT) @(negedge clk);
    if (sb.fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> packbits_encoder.f
sv/pbe_pkg.sv
sv/pbe_ram.sv
sv/pbe_packer.sv
sv/pbe_datapath.sv
sv/pbe_ctrl.sv
sv/packbits_encoder.sv
tb/testbench.sv
